// ===== src/word_frequency_counter_defines.svh =====
// Assertion macros for the word frequency counter.
// Used by the top level; no other dependencies.
`ifndef WORD_FREQUENCY_COUNTER_DEFINES_SVH
`define WORD_FREQUENCY_COUNTER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define WFC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication outside reset.
`define WFC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== src/wfc_pkg.sv =====
// Shared types and constants for the word frequency counter.
// No dependencies.
package wfc_pkg;
	localparam int TableDepth = 1024;
	localparam int MaxWordLen = 14;
	localparam logic [23:0] CountMax = 24'hFFFFFF;

	typedef enum logic [1:0] {REQ_TEXT, REQ_FLUSH, REQ_SORT, REQ_READ} req_t;
	typedef enum logic [1:0] {RESP_WORD, RESP_SORT, RESP_READ} resp_kind_t;
	localparam logic [1:0] StNew = 2'd0;
	localparam logic [1:0] StHit = 2'd1;
	localparam logic [1:0] StFull = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] char_byte;
		logic [9:0] read_index;
	} in_t;

	typedef struct packed {
		logic [1:0]  resp_kind;
		logic [1:0]  status;
		logic [9:0]  entry_index;
		logic [23:0] word_count;
		logic [63:0] word_low;
		logic [63:0] word_high;
		logic [4:0]  word_length;
		logic        entry_valid;
	} out_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SRCH, S_SRCH_CHK, S_APPEND, S_HITWR,
		S_SORT_I, S_SORT_RD, S_SORT_CMP, S_SORT_INS,
		S_READ, S_READ_CHK, S_OUT
	} state_t;

	function automatic logic [4:0] length_of(input logic [127:0] w);
		logic [4:0] n;
		logic stop;
		n = '0;
		stop = 1'b0;
		for (int k = 0; k < 16; k++) begin
			if (w[8*k +: 8] == 8'd0) stop = 1'b1;
			if (!stop) n = n + 5'd1;
		end
		return n;
	endfunction
endpackage

// ===== src/wfc_table.sv =====
// Word and count memories of the word frequency counter.
// Depends on wfc_pkg. One read port and one write port, registered read data.
module wfc_table #(
	parameter int DEPTH = wfc_pkg::TableDepth,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic [AW-1:0] rd_addr,
	output logic [127:0]  rd_word,
	output logic [23:0]   rd_count,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [127:0]  wr_word,
	input  logic [23:0]   wr_count
);
	logic [151:0] mem [DEPTH];
	logic [151:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= {wr_count, wr_word};
		rd_q <= mem[rd_addr];
	end

	assign rd_word  = rd_q[127:0];
	assign rd_count = rd_q[151:128];
endmodule

// ===== src/word_frequency_counter.sv =====
// Top level of the word frequency counter: tokenizer, table control and sort.
// Depends on wfc_pkg, wfc_table and word_frequency_counter_defines.svh.
//
// channel | direction | handshake        | payload
// in      | input     | in_valid/in_ready | wfc_pkg::in_t
// out     | output    | out_valid/out_ready | wfc_pkg::out_t
//
// A text byte that does not end a word is taken without leaving idle. A finished word
// walks the occupied entries through the single memory read port. Sort is an
// insertion sort over the same port. Reset leaves the memory contents alone;
// entries at or above the fill count read as empty.
// One transaction is worked at a time; a held result stalls the next one.
`include "word_frequency_counter_defines.svh"
module word_frequency_counter #(
	parameter int TABLE_DEPTH = wfc_pkg::TableDepth,
	parameter int MAX_WORD_LEN = wfc_pkg::MaxWordLen
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  wfc_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output wfc_pkg::out_t out_data
);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	wfc_pkg::state_t state_q, state_d;
	logic [127:0] buf_q;
	logic [4:0] fill_q;
	logic [CW-1:0] occ_q;
	logic [CW-1:0] i_q, j_q;
	logic [127:0] word_q;
	logic [23:0] cnt_q;
	logic [9:0] ridx_q;
	wfc_pkg::out_t res_q;
	wfc_pkg::out_t res_start;

	logic [AW-1:0] rd_addr;
	logic [127:0] rd_word;
	logic [23:0] rd_count;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [127:0] wr_word;
	logic [23:0] wr_count;

	wfc_table #(.DEPTH(TABLE_DEPTH)) u_table (
		.clk, .rd_addr, .rd_word, .rd_count,
		.wr_en, .wr_addr, .wr_word, .wr_count
	);

	logic accept;
	logic [7:0] ch, lc;
	logic is_word, at_max, finish;
	assign accept = in_valid && in_ready;
	assign ch = in_data.char_byte;
	assign is_word = (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A)
		|| (ch >= 8'h61 && ch <= 8'h7A);
	assign lc = (ch >= 8'h41 && ch <= 8'h5A) ? ch + 8'd32 : ch;
	assign at_max = fill_q >= 5'(MAX_WORD_LEN);
	assign finish = (in_data.req_type == wfc_pkg::REQ_TEXT && (at_max || (!is_word
		&& fill_q != 5'd0))) || (in_data.req_type == wfc_pkg::REQ_FLUSH && fill_q != 5'd0);

	assign in_ready = state_q == wfc_pkg::S_IDLE;
	assign out_valid = state_q == wfc_pkg::S_OUT;
	assign out_data = res_q;

	// Starting result for an accepted transaction; a word starts out with the table-full status.
	always_comb begin
		res_start = '0;
		unique case (wfc_pkg::req_t'(in_data.req_type))
			wfc_pkg::REQ_SORT: res_start.resp_kind = wfc_pkg::RESP_SORT;
			wfc_pkg::REQ_READ: begin
				res_start.resp_kind = wfc_pkg::RESP_READ;
				res_start.entry_index = in_data.read_index;
			end
			default: begin
				res_start.resp_kind = wfc_pkg::RESP_WORD;
				res_start.status = wfc_pkg::StFull;
				res_start.word_low = buf_q[63:0];
				res_start.word_high = buf_q[127:64];
				res_start.word_length = fill_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= wfc_pkg::S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		rd_addr = AW'(i_q);
		wr_en = 1'b0;
		wr_addr = AW'(j_q);
		wr_word = word_q;
		wr_count = cnt_q;
		unique case (state_q)
			wfc_pkg::S_IDLE: begin
				if (accept) begin
					unique case (wfc_pkg::req_t'(in_data.req_type))
						wfc_pkg::REQ_TEXT, wfc_pkg::REQ_FLUSH:
							if (finish) state_d = (occ_q >= CW'(TABLE_DEPTH)) ?
								wfc_pkg::S_OUT : wfc_pkg::S_SRCH;
						wfc_pkg::REQ_SORT: state_d = wfc_pkg::S_SORT_I;
						wfc_pkg::REQ_READ: state_d = wfc_pkg::S_READ;
						default: state_d = wfc_pkg::S_IDLE;
					endcase
				end
			end
			wfc_pkg::S_SRCH: state_d = (i_q >= occ_q) ? wfc_pkg::S_APPEND : wfc_pkg::S_SRCH_CHK;
			wfc_pkg::S_SRCH_CHK: state_d = (rd_word == word_q) ? wfc_pkg::S_HITWR :
				wfc_pkg::S_SRCH;
			wfc_pkg::S_APPEND: begin
				wr_en = 1'b1; wr_addr = AW'(occ_q); wr_count = 24'd1;
				state_d = wfc_pkg::S_OUT;
			end
			wfc_pkg::S_HITWR: begin
				wr_en = 1'b1; wr_addr = AW'(j_q); wr_count = cnt_q;
				state_d = wfc_pkg::S_OUT;
			end
			wfc_pkg::S_SORT_I: begin
				// Fetch entry i as the key, then walk j down from i.
				state_d = (i_q >= occ_q) ? wfc_pkg::S_OUT : wfc_pkg::S_SORT_RD;
			end
			wfc_pkg::S_SORT_RD: begin
				rd_addr = AW'(j_q - CW'(1));
				state_d = wfc_pkg::S_SORT_CMP;
			end
			wfc_pkg::S_SORT_CMP: begin
				if (rd_count < cnt_q) begin
					wr_en = 1'b1; wr_word = rd_word; wr_count = rd_count;
					state_d = (j_q == CW'(1)) ? wfc_pkg::S_SORT_INS : wfc_pkg::S_SORT_RD;
				end else state_d = wfc_pkg::S_SORT_INS;
			end
			wfc_pkg::S_SORT_INS: begin
				wr_en = 1'b1;
				state_d = wfc_pkg::S_SORT_I;
			end
			wfc_pkg::S_READ: begin
				rd_addr = AW'(ridx_q);
				state_d = wfc_pkg::S_READ_CHK;
			end
			wfc_pkg::S_READ_CHK: state_d = wfc_pkg::S_OUT;
			wfc_pkg::S_OUT: if (out_ready) state_d = wfc_pkg::S_IDLE;
			default: state_d = wfc_pkg::S_IDLE;
		endcase
	end

	// Entry i is fetched in S_SORT_I's cycle; its data shows up in S_SORT_RD.
	logic key_load;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= '0; fill_q <= '0; occ_q <= '0; key_load <= 1'b0;
		end else begin
			key_load <= state_q == wfc_pkg::S_SORT_I && i_q < occ_q;
			if (accept && in_data.req_type == wfc_pkg::REQ_TEXT && !at_max && is_word) begin
				buf_q[8*fill_q[3:0] +: 8] <= lc;
				fill_q <= fill_q + 5'd1;
			end else if (accept && finish) begin
				buf_q <= '0; fill_q <= '0;
			end
			if (state_q == wfc_pkg::S_APPEND) occ_q <= occ_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			wfc_pkg::S_IDLE: begin
				ridx_q <= in_data.read_index;
				word_q <= buf_q;
				i_q <= (in_data.req_type == wfc_pkg::REQ_SORT) ? CW'(1) : '0;
				res_q <= res_start;
			end
			wfc_pkg::S_SRCH: begin
				j_q <= i_q;
				i_q <= i_q + CW'(1);
			end
			wfc_pkg::S_SRCH_CHK: begin
				cnt_q <= (rd_count == wfc_pkg::CountMax) ? rd_count : rd_count + 24'd1;
			end
			wfc_pkg::S_APPEND: begin
				res_q.status <= wfc_pkg::StNew;
				res_q.entry_index <= 10'(occ_q);
				res_q.word_count <= 24'd1;
				res_q.entry_valid <= 1'b1;
			end
			wfc_pkg::S_HITWR: begin
				res_q.status <= wfc_pkg::StHit;
				res_q.entry_index <= 10'(j_q);
				res_q.word_count <= cnt_q;
				res_q.entry_valid <= 1'b1;
			end
			wfc_pkg::S_SORT_I: j_q <= i_q;
			wfc_pkg::S_SORT_RD: begin
				if (key_load) begin
					word_q <= rd_word; cnt_q <= rd_count;
				end
			end
			wfc_pkg::S_SORT_CMP: if (rd_count < cnt_q) j_q <= j_q - CW'(1);
			wfc_pkg::S_SORT_INS: i_q <= i_q + CW'(1);
			wfc_pkg::S_READ_CHK: begin
				// The fill count never exceeds the depth, so this also bounds the index.
				if ({3'b000, ridx_q} < 13'(occ_q)) begin
					res_q.word_count <= rd_count;
					res_q.word_low <= rd_word[63:0];
					res_q.word_high <= rd_word[127:64];
					res_q.word_length <= wfc_pkg::length_of(rd_word);
					res_q.entry_valid <= rd_count != 24'd0;
				end
			end
			default: ;
		endcase
	end

	`WFC_ASSERT_IMP(a_occ_bound, 1'b1, occ_q <= CW'(TABLE_DEPTH))
	`WFC_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= 5'(MAX_WORD_LEN))
	`WFC_ASSERT_NXT(a_append_grows, state_q == wfc_pkg::S_APPEND, occ_q == $past(occ_q) + CW'(1))
	`WFC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

// ===== tb/sv/word_frequency_counter_tb.sv =====
// Self-checking testbench for word_frequency_counter: directed table, then random traffic.
// Depends on wfc_pkg and the word_frequency_counter RTL.
module word_frequency_counter_tb;
	import wfc_pkg::*;

	localparam int ItemTarget = 580;
	localparam longint CycleLimit = 6000000;

	typedef struct {
		in_t  item;
		bit   typed;
		out_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	// Shadow copy of the word table.
	logic [127:0] shadow_words [TableDepth];
	logic [23:0] shadow_counts [TableDepth];
	int unsigned shadow_used = 0;
	logic [127:0] cur_word = '0;
	int unsigned cur_fill = 0;

	out_t pending_results[$];
	int unsigned mismatches = 0;
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned sorts_sent = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	longint cycles = 0;

	word_frequency_counter dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #5 clk = ~clk;

	function automatic out_t make_result(logic [1:0] kind, logic [1:0] st, logic [9:0] idx,
			logic [23:0] cnt, logic [127:0] w, logic [4:0] len, logic vld);
		out_t r;
		r.resp_kind = kind;
		r.status = st;
		r.entry_index = idx;
		r.word_count = cnt;
		r.word_low = w[63:0];
		r.word_high = w[127:64];
		r.word_length = len;
		r.entry_valid = vld;
		return r;
	endfunction

	function automatic out_t count_word();
		logic [127:0] w;
		logic [4:0] len;
		w = cur_word;
		len = cur_fill[4:0];
		cur_word = '0;
		cur_fill = 0;
		if (shadow_used >= TableDepth)
			return make_result(RESP_WORD, StFull, '0, '0, w, len, 1'b0);
		for (int i = 0; i < shadow_used; i++) begin
			if (shadow_words[i] == w) begin
				if (shadow_counts[i] != CountMax) shadow_counts[i]++;
				return make_result(RESP_WORD, StHit, i[9:0], shadow_counts[i], w, len, 1'b1);
			end
		end
		shadow_words[shadow_used] = w;
		shadow_counts[shadow_used] = 24'd1;
		shadow_used++;
		return make_result(RESP_WORD, StNew, 10'(shadow_used - 1), 24'd1, w, len, 1'b1);
	endfunction

	// Advances the shadow table by one transaction; returns 1 when a result is due.
	function automatic bit apply_request(in_t it, output out_t r);
		logic [7:0] c;
		logic [127:0] w;
		logic [23:0] cnt;
		int unsigned j, len;
		bit is_word;
		r = '0;
		c = it.char_byte;
		case (it.req_type)
			REQ_TEXT: begin
				is_word = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z")
					|| (c >= "a" && c <= "z");
				// A byte arriving on a full-length word closes it and is dropped.
				if (cur_fill >= MaxWordLen) begin
					r = count_word();
					return 1'b1;
				end
				if (is_word) begin
					if (c >= "A" && c <= "Z") c = c + 8'd32;
					cur_word[8*cur_fill +: 8] = c;
					cur_fill++;
					return 1'b0;
				end
				if (cur_fill > 0) begin
					r = count_word();
					return 1'b1;
				end
				return 1'b0;
			end
			REQ_FLUSH: begin
				if (cur_fill > 0) begin
					r = count_word();
					return 1'b1;
				end
				return 1'b0;
			end
			REQ_SORT: begin
				for (int i = 1; i < shadow_used; i++) begin
					cnt = shadow_counts[i];
					w = shadow_words[i];
					j = i;
					while (j > 0 && shadow_counts[j-1] < cnt) begin
						shadow_counts[j] = shadow_counts[j-1];
						shadow_words[j] = shadow_words[j-1];
						j--;
					end
					shadow_counts[j] = cnt;
					shadow_words[j] = w;
				end
				r = make_result(RESP_SORT, StNew, '0, '0, '0, '0, 1'b0);
				return 1'b1;
			end
			default: begin
				if (it.read_index < shadow_used) begin
					w = shadow_words[it.read_index];
					len = 0;
					while (len < 16 && w[8*len +: 8] != 8'd0) len++;
					cnt = shadow_counts[it.read_index];
					r = make_result(RESP_READ, StNew, it.read_index, cnt, w, len[4:0],
						cnt != 0);
				end else begin
					r = make_result(RESP_READ, StNew, it.read_index, '0, '0, '0, 1'b0);
				end
				return 1'b1;
			end
		endcase
	endfunction

	function automatic in_t req(logic [1:0] kind, logic [7:0] c, logic [9:0] idx);
		in_t it;
		it.req_type = kind;
		it.char_byte = c;
		it.read_index = idx;
		return it;
	endfunction

	task automatic send(in_t it, bit typed = 1'b0, out_t typed_res = '0);
		out_t r;
		int unsigned gap;
		gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		if (it.req_type == REQ_SORT) sorts_sent++;
		if (apply_request(it, r)) pending_results.push_back(typed ? typed_res : r);
	endtask

	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			out_t e;
			if (pending_results.size() == 0) begin
				$error("unexpected result transaction: 0x%0h", out_data);
				mismatches++;
			end else begin
				e = pending_results.pop_front();
				results_seen++;
				check_field("resp_kind", e.resp_kind, out_data.resp_kind);
				check_field("status", e.status, out_data.status);
				check_field("entry_index", e.entry_index, out_data.entry_index);
				check_field("word_count", e.word_count, out_data.word_count);
				check_field("word_low", e.word_low, out_data.word_low);
				check_field("word_high", e.word_high, out_data.word_high);
				check_field("word_length", e.word_length, out_data.word_length);
				check_field("entry_valid", e.entry_valid, out_data.entry_valid);
			end
		end
	end

	always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	string vocab [24];
	row_t directed [$];
	int unsigned pick;
	string s;
	logic [7:0] sep;

	initial begin
		// Directed rows: empty-table behavior, character class edges, repeats.
		directed.push_back('{req(REQ_READ, '0, 10'd0), 1'b1,
			make_result(RESP_READ, StNew, '0, '0, '0, '0, 1'b0)});
		directed.push_back('{req(REQ_SORT, '0, '0), 1'b1,
			make_result(RESP_SORT, StNew, '0, '0, '0, '0, 1'b0)});
		directed.push_back('{req(REQ_FLUSH, '0, '0), 1'b0, '0});
		directed.push_back('{req(REQ_TEXT, 8'h00, '0), 1'b0, '0});
		s = "Az09";
		for (int i = 0; i < 4; i++) directed.push_back('{req(REQ_TEXT, s[i], '0), 1'b0, '0});
		directed.push_back('{req(REQ_TEXT, 8'hFF, '0), 1'b0, '0});
		s = "aZ09";
		for (int i = 0; i < 4; i++) directed.push_back('{req(REQ_TEXT, s[i], '0), 1'b0, '0});
		directed.push_back('{req(REQ_FLUSH, '0, '0), 1'b0, '0});
		s = "@[`{/:";
		for (int i = 0; i < 6; i++) directed.push_back('{req(REQ_TEXT, s[i], '0), 1'b0, '0});
		directed.push_back('{req(REQ_SORT, '0, '0), 1'b0, '0});
		directed.push_back('{req(REQ_READ, '0, 10'd0), 1'b0, '0});
		directed.push_back('{req(REQ_READ, '0, 10'd1), 1'b1,
			make_result(RESP_READ, StNew, 10'd1, '0, '0, '0, 1'b0)});
		directed.push_back('{req(REQ_READ, '0, 10'h3FF), 1'b1,
			make_result(RESP_READ, StNew, 10'h3FF, '0, '0, '0, 1'b0)});

		// Vocabulary spans one character up to past the maximum word length.
		s = "abcdefghijklmnopqrstuvwxyz0123456789";
		foreach (vocab[i]) begin
			vocab[i] = "";
			for (int k = 0; k < $urandom_range(1, 17); k++)
				vocab[i] = {vocab[i], s.substr($urandom_range(35), $urandom_range(35))};
			if (vocab[i].len() == 0) vocab[i] = "q";
		end
		vocab[0] = "abcdefghijklmnop";
		vocab[1] = "x";

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send(directed[i].item, directed[i].typed, directed[i].res);
		in_valid <= 1'b0;
		drain();

		while (items_sent < ItemTarget) begin
			case (items_sent * 4 / ItemTarget)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 63; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 63; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			if (items_sent > ItemTarget / 2 && items_sent < ItemTarget / 2 + 8) begin
				// Hold the sender back until the block has nothing outstanding.
				in_valid <= 1'b0;
				drain();
			end
			pick = $urandom_range(99);
			if (pick < 70) begin
				s = vocab[$urandom_range(23)];
				for (int i = 0; i < s.len(); i++)
					if ($urandom_range(1) && s[i] >= "a") s[i] = s[i] - 8'd32;
				do sep = 8'($urandom_range(255));
				while ((sep >= "0" && sep <= "9") || (sep >= "A" && sep <= "Z")
					|| (sep >= "a" && sep <= "z"));
				for (int i = 0; i < s.len(); i++)
					send(req(REQ_TEXT, s[i], 10'($urandom())));
				if ($urandom_range(3) == 0)
					send(req(REQ_FLUSH, 8'($urandom()), 10'($urandom())));
				else send(req(REQ_TEXT, sep, 10'($urandom())));
			end else if (pick < 82) send(req(REQ_TEXT, 8'($urandom()), 10'($urandom())));
			else if (pick < 86) send(req(REQ_FLUSH, 8'($urandom()), 10'($urandom())));
			else if (pick < 88) send(req(REQ_SORT, 8'($urandom()), 10'($urandom())));
			else if (pick < 94)
				send(req(REQ_READ, 8'($urandom()), 10'($urandom_range(shadow_used))));
			else send(req(REQ_READ, 8'($urandom()), 10'($urandom())));
		end

		in_valid <= 1'b0;
		drain();
		repeat (50) @(posedge clk);

		$display("Sent %0d transactions and checked %0d results, %0d of the requests sorts.",
			items_sent, results_seen, sorts_sent);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+src
src/wfc_pkg.sv
src/wfc_table.sv
src/word_frequency_counter.sv
tb/sv/word_frequency_counter_tb.sv
